[rtl/swls_pkg.sv]
// ----------------------------------------------------------------------------
// swls_pkg: shared types and constants for the switching-well Langevin stepper
// Sequencer states, register map, field widths and register reset values.
// ----------------------------------------------------------------------------
package swls_pkg;

  // Histogram geometry
  localparam int HIST_BINS = 256;
  localparam int BIN_AW    = $clog2(HIST_BINS);

  // Shared multiplier operand and product widths (signed)
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;

  // Configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_DRIFT_GAIN     = 3'd0;
  localparam logic [2:0] REG_WELL_OFFSET    = 3'd1;
  localparam logic [2:0] REG_FLIP_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_HIST_LOW       = 3'd3;
  localparam logic [2:0] REG_HIST_HIGH      = 3'd4;
  localparam logic [2:0] REG_BIN_SCALE      = 3'd5;
  localparam logic [2:0] REG_MAX_STEPS      = 3'd6;

  // Register reset values
  localparam logic [23:0] DRIFT_GAIN_RST     = 24'd16777;
  localparam logic [22:0] WELL_OFFSET_RST    = 23'd327680;
  localparam logic [22:0] FLIP_THRESHOLD_RST = 23'd16384;
  localparam logic [23:0] HIST_LOW_RST       = 24'hFE0000;
  localparam logic [23:0] HIST_HIGH_RST      = 24'h020000;
  localparam logic [15:0] BIN_SCALE_RST      = 16'd12800;
  localparam logic [31:0] MAX_STEPS_RST      = 32'd10000000;

  // Input function codes
  localparam logic FUNC_STEP = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DRIFT,
    ST_POS,
    ST_SQ,
    ST_BIN,
    ST_IDX,
    ST_WR,
    ST_OUT
  } swls_state_t;

endpackage

[rtl/switching_well_langevin_step.sv]
// A step transaction (in_func 0) moves the particle one Euler-Maruyama step:
// one shared 26x26 signed multiplier forms the drift, the square and the bin
// index in turn, and the histogram RAM is updated by a read-modify-write on
// its separate read and write ports. A read transaction (in_func 1) does a
// registered RAM read; a step after the run is done skips to the result.
// The histogram needs no clearing pass: each bin carries a valid bit cleared
// at reset, and an invalid bin reads zero. The block takes one transaction at
// a time; in_stall is high while it works. The result register frees the
// input side as soon as the result is loaded. Configuration must be written
// through the APB-style port while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
// switching_well_langevin_step: fixed-point two-well Langevin stepper
// Drift toward the active well, external noise, flip counting, running sum
// of squares and a position histogram; all multiplies share one multiplier.
// ----------------------------------------------------------------------------
module switching_well_langevin_step (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic signed [23:0]          in_noise,
  input  logic [7:0]                  in_bin_index,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [23:0]          out_position,
  output logic                        out_pull_right,
  output logic [31:0]                 out_switches,
  output logic [31:0]                 out_steps_taken,
  output logic [62:0]                 out_square_total,
  output logic [31:0]                 out_bin_count,
  output logic                        out_done_res,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [swls_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [swls_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [swls_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  // Configuration registers
  logic [23:0] drift_gain_r;
  logic [22:0] well_offset_r;
  logic [22:0] flip_thr_r;
  logic [23:0] hist_low_r;
  logic [23:0] hist_high_r;
  logic [15:0] bin_scale_r;
  logic [31:0] max_steps_r;

  // Simulation state
  logic [23:0] pos_r;
  logic        side_r;
  logic [31:0] flip_total_r;
  logic [31:0] step_total_r;
  logic [62:0] sq_acc_r;

  // Transaction and sequencer registers
  swls_pkg::swls_state_t state_r, state_nxt;
  logic                     func_r;
  logic [23:0]              noise_r;
  logic [7:0]               bidx_r;
  logic signed [swls_pkg::PROD_W-1:0] prod_r;
  logic                     inrange_r;
  logic [swls_pkg::BIN_AW-1:0] widx_r;
  logic [31:0]              rd_data_r;
  logic                     rd_valid_r;

  // Histogram RAM and its valid bits
  logic [31:0] hist_mem [swls_pkg::HIST_BINS];
  logic [swls_pkg::HIST_BINS-1:0] hvalid_r;

  // Result register
  logic        out_valid_r;
  logic [23:0] out_position_r;
  logic        out_pull_right_r;
  logic [31:0] out_switches_r;
  logic [31:0] out_steps_taken_r;
  logic [62:0] out_square_total_r;
  logic [31:0] out_bin_count_r;
  logic        out_done_res_r;

  // Control and datapath nets
  logic                               in_acc;
  logic                               cfg_wr;
  logic                               out_load;
  logic signed [swls_pkg::MUL_W-1:0]  mul_a;
  logic signed [swls_pkg::MUL_W-1:0]  mul_b;
  logic signed [swls_pkg::PROD_W-1:0] mul_p;
  logic                               mem_re;
  logic [swls_pkg::BIN_AW-1:0]        mem_raddr;
  logic                               mem_we;
  logic [31:0]                        mem_wdata;

  logic signed [swls_pkg::MUL_W-1:0]  pos_ext;
  logic signed [swls_pkg::MUL_W-1:0]  off_ext;
  logic signed [swls_pkg::MUL_W-1:0]  target;
  logic signed [swls_pkg::MUL_W-1:0]  delta;
  logic signed [swls_pkg::MUL_W-1:0]  hl_ext;
  logic signed [26:0]                 np_sum;
  logic [23:0]                        np_sat;
  logic signed [24:0]                 np25;
  logic signed [24:0]                 thr25;
  logic                               flip;
  logic [30:0]                        sq;
  logic [63:0]                        sq_sum;
  logic                               in_range;
  logic [15:0]                        idx_full;
  logic [15:0]                        idx_clamp;
  logic [31:0]                        bidx_ext;
  logic                               bidx_ok;
  logic [31:0]                        cur_cnt;
  logic                               done_now;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_stall = (state_r != swls_pkg::ST_IDLE);
  assign out_load = (state_r == swls_pkg::ST_OUT) && !(out_valid_r && out_stall);

  // Drift operands: target well minus current position
  assign pos_ext = {{2{pos_r[23]}}, pos_r};
  assign off_ext = {3'b000, well_offset_r};
  assign target  = side_r ? off_ext : -off_ext;
  assign delta   = target - pos_ext;
  assign hl_ext  = {{2{hist_low_r[23]}}, hist_low_r};

  // New position: floor shift of the drift product, add noise, saturate
  assign np_sum = {{3{pos_r[23]}}, pos_r} + prod_r[50:24]
                + {{3{noise_r[23]}}, noise_r};
  always_comb begin
    if (np_sum > 27'sd8388607) begin
      np_sat = 24'h7FFFFF;
    end else if (np_sum < -27'sd8388608) begin
      np_sat = 24'h800000;
    end else begin
      np_sat = np_sum[23:0];
    end
  end

  // Flip test on the far side of the origin
  assign np25  = {np_sat[23], np_sat};
  assign thr25 = {2'b00, flip_thr_r};
  assign flip  = side_r ? (np25 >= thr25) : (np25 <= -thr25);

  // Square accumulation, saturating at the 63-bit maximum
  assign sq     = prod_r[46:16];
  assign sq_sum = {1'b0, sq_acc_r} + {33'd0, sq};

  // Histogram range test and bin index
  assign in_range  = ($signed(pos_r) > $signed(hist_low_r)) &&
                     ($signed(pos_r) < $signed(hist_high_r));
  assign idx_full  = prod_r[39:24];
  assign idx_clamp = (idx_full >= 16'(swls_pkg::HIST_BINS)) ?
                     16'(swls_pkg::HIST_BINS - 1) : idx_full;
  assign bidx_ext  = 32'(bidx_r);
  assign bidx_ok   = bidx_ext < 32'(swls_pkg::HIST_BINS);

  // Bin update value, held at the 32-bit maximum
  assign cur_cnt   = rd_valid_r ? rd_data_r : 32'd0;
  assign mem_wdata = (&cur_cnt) ? cur_cnt : cur_cnt + 32'd1;

  assign done_now = (step_total_r >= max_steps_r);

  // Shared multiplier
  assign mul_p = mul_a * mul_b;

  // Sequencer: next state and unit control
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    case (state_r)
      swls_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_func == swls_pkg::FUNC_READ) begin
            state_nxt = swls_pkg::ST_READ;
          end else if (done_now) begin
            state_nxt = swls_pkg::ST_OUT;
          end else begin
            state_nxt = swls_pkg::ST_DRIFT;
          end
        end
      end
      swls_pkg::ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = bidx_ext[swls_pkg::BIN_AW-1:0];
        state_nxt = swls_pkg::ST_OUT;
      end
      swls_pkg::ST_DRIFT: begin
        mul_a     = delta;
        mul_b     = {2'b00, drift_gain_r};
        state_nxt = swls_pkg::ST_POS;
      end
      swls_pkg::ST_POS: begin
        state_nxt = swls_pkg::ST_SQ;
      end
      swls_pkg::ST_SQ: begin
        mul_a     = pos_ext;
        mul_b     = pos_ext;
        state_nxt = swls_pkg::ST_BIN;
      end
      swls_pkg::ST_BIN: begin
        mul_a     = pos_ext - hl_ext;
        mul_b     = {10'd0, bin_scale_r};
        state_nxt = swls_pkg::ST_IDX;
      end
      swls_pkg::ST_IDX: begin
        mem_re    = 1'b1;
        mem_raddr = idx_clamp[swls_pkg::BIN_AW-1:0];
        state_nxt = swls_pkg::ST_WR;
      end
      swls_pkg::ST_WR: begin
        mem_we    = inrange_r;
        state_nxt = swls_pkg::ST_OUT;
      end
      swls_pkg::ST_OUT: begin
        if (out_load) begin
          state_nxt = swls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swls_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swls_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers: write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drift_gain_r  <= swls_pkg::DRIFT_GAIN_RST;
      well_offset_r <= swls_pkg::WELL_OFFSET_RST;
      flip_thr_r    <= swls_pkg::FLIP_THRESHOLD_RST;
      hist_low_r    <= swls_pkg::HIST_LOW_RST;
      hist_high_r   <= swls_pkg::HIST_HIGH_RST;
      bin_scale_r   <= swls_pkg::BIN_SCALE_RST;
      max_steps_r   <= swls_pkg::MAX_STEPS_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        swls_pkg::REG_DRIFT_GAIN:     drift_gain_r  <= cfg_pwdata[23:0];
        swls_pkg::REG_WELL_OFFSET:    well_offset_r <= cfg_pwdata[22:0];
        swls_pkg::REG_FLIP_THRESHOLD: flip_thr_r    <= cfg_pwdata[22:0];
        swls_pkg::REG_HIST_LOW:       hist_low_r    <= cfg_pwdata[23:0];
        swls_pkg::REG_HIST_HIGH:      hist_high_r   <= cfg_pwdata[23:0];
        swls_pkg::REG_BIN_SCALE:      bin_scale_r   <= cfg_pwdata[15:0];
        swls_pkg::REG_MAX_STEPS:      max_steps_r   <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_paddr[4:2])
      swls_pkg::REG_DRIFT_GAIN:     cfg_prdata = {8'd0, drift_gain_r};
      swls_pkg::REG_WELL_OFFSET:    cfg_prdata = {9'd0, well_offset_r};
      swls_pkg::REG_FLIP_THRESHOLD: cfg_prdata = {9'd0, flip_thr_r};
      swls_pkg::REG_HIST_LOW:       cfg_prdata = {8'd0, hist_low_r};
      swls_pkg::REG_HIST_HIGH:      cfg_prdata = {8'd0, hist_high_r};
      swls_pkg::REG_BIN_SCALE:      cfg_prdata = {16'd0, bin_scale_r};
      swls_pkg::REG_MAX_STEPS:      cfg_prdata = max_steps_r;
      default:                      cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // Capture the transaction and the multiplier product
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_func;
      noise_r <= in_noise;
      bidx_r  <= in_bin_index;
    end
    if (state_r == swls_pkg::ST_DRIFT || state_r == swls_pkg::ST_SQ ||
        state_r == swls_pkg::ST_BIN) begin
      prod_r <= mul_p;
    end
    if (state_r == swls_pkg::ST_BIN) begin
      inrange_r <= in_range && ($signed(hist_low_r) < $signed(hist_high_r));
    end
    if (state_r == swls_pkg::ST_IDX) begin
      widx_r <= mem_raddr;
    end
  end

  // Advance the particle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      side_r       <= 1'b1;
      flip_total_r <= '0;
      step_total_r <= '0;
      sq_acc_r     <= '0;
    end else begin
      if (state_r == swls_pkg::ST_POS) begin
        pos_r        <= np_sat;
        step_total_r <= step_total_r + 32'd1;
        if (flip) begin
          side_r <= !side_r;
          if (!(&flip_total_r)) begin
            flip_total_r <= flip_total_r + 32'd1;
          end
        end
      end
      if (state_r == swls_pkg::ST_BIN) begin
        sq_acc_r <= sq_sum[63] ? {63{1'b1}} : sq_sum[62:0];
      end
    end
  end

  // Histogram RAM: one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[widx_r] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= hist_mem[mem_raddr];
    end
  end

  // Bin valid bits: an unwritten bin reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r   <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (mem_we) begin
        hvalid_r[widx_r] <= 1'b1;
      end
      if (mem_re) begin
        rd_valid_r <= hvalid_r[mem_raddr];
      end
    end
  end

  // Result register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_position_r     <= pos_r;
      out_pull_right_r   <= side_r;
      out_switches_r     <= flip_total_r;
      out_steps_taken_r  <= step_total_r;
      out_square_total_r <= sq_acc_r;
      out_bin_count_r    <= (func_r == swls_pkg::FUNC_READ && bidx_ok) ? cur_cnt : 32'd0;
      out_done_res_r     <= done_now;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_position_r;
  assign out_pull_right   = out_pull_right_r;
  assign out_switches     = out_switches_r;
  assign out_steps_taken  = out_steps_taken_r;
  assign out_square_total = out_square_total_r;
  assign out_bin_count    = out_bin_count_r;
  assign out_done_res     = out_done_res_r;

  // A transaction taken in always starts the sequencer
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != swls_pkg::ST_IDLE))
    else $error("accepted transaction did not start the sequencer");

  // Each position update counts exactly one step
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swls_pkg::ST_POS) |=> (step_total_r == $past(step_total_r) + 32'd1))
    else $error("step counter did not advance on a position update");

  // The switch counter moves only together with the pull side
  a_flip_side: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (flip_total_r != $past(flip_total_r)) |-> (side_r != $past(side_r)))
    else $error("switch counter moved without a side change");

  // The running sum of squares never decreases
  a_sq_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (sq_acc_r >= $past(sq_acc_r)))
    else $error("sum of squares decreased");

endmodule

[verif/walker_check_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// walker_check_pkg: result tracking for the switching-well Langevin stepper
// Holds a bit-exact shadow of the particle state, its registers and the
// histogram, predicts one report per accepted transaction and checks the
// reports that the block returns, in order.
// ----------------------------------------------------------------------------
package walker_check_pkg;

  import swls_pkg::*;

  // One report, fields in port order
  typedef struct packed {
    logic signed [23:0] position;
    logic               pull_right;
    logic [31:0]        switches;
    logic [31:0]        steps_taken;
    logic [62:0]        square_total;
    logic [31:0]        bin_count;
    logic               done_res;
  } walker_report_t;

  localparam longint unsigned SQ_SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint          POS_TOP    = 64'sd8388607;
  localparam longint          POS_BOTTOM = -64'sd8388608;

  class walker_tracker;

    // shadow registers
    longint      gain;
    longint      offset;
    longint      thresh;
    longint      h_lo;
    longint      h_hi;
    longint      scale;
    logic [31:0] step_limit;

    // shadow particle state
    longint          pos;
    logic            pull_r;
    logic [31:0]     flip_count;
    logic [31:0]     step_count;
    longint unsigned sq_sum;
    logic [31:0]     bin_hits [HIST_BINS];

    walker_report_t predicted_reports [$];
    int errors;

    function new();
      gain       = longint'(DRIFT_GAIN_RST);
      offset     = longint'(WELL_OFFSET_RST);
      thresh     = longint'(FLIP_THRESHOLD_RST);
      h_lo       = longint'($signed(HIST_LOW_RST));
      h_hi       = longint'($signed(HIST_HIGH_RST));
      scale      = longint'(BIN_SCALE_RST);
      step_limit = MAX_STEPS_RST;
      pos        = 0;
      pull_r     = 1'b1;
      flip_count = '0;
      step_count = '0;
      sq_sum     = 0;
      errors     = 0;
      foreach (bin_hits[i]) bin_hits[i] = '0;
    endfunction

    // Mirror a register write; unknown indexes change nothing
    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_DRIFT_GAIN:     gain = longint'(val[23:0]);
        REG_WELL_OFFSET:    offset = longint'(val[22:0]);
        REG_FLIP_THRESHOLD: thresh = longint'(val[22:0]);
        REG_HIST_LOW:       h_lo = longint'($signed(val[23:0]));
        REG_HIST_HIGH:      h_hi = longint'($signed(val[23:0]));
        REG_BIN_SCALE:      scale = longint'(val[15:0]);
        REG_MAX_STEPS:      step_limit = val;
        default: ;
      endcase
    endfunction

    // One Euler-Maruyama step with drift toward the active well
    function void advance_walker(longint noise);
      longint tgt;
      longint prod;
      longint np;
      longint idx;
      longint unsigned sq;
      tgt  = pull_r ? offset : -offset;
      prod = gain * (tgt - pos);
      np   = pos + (prod >>> 24) + noise;
      if (np > POS_TOP) np = POS_TOP;
      if (np < POS_BOTTOM) np = POS_BOTTOM;
      pos = np;

      // accumulate the square, saturating
      sq = longint'(np * np) >> 16;
      if (sq > SQ_SUM_MAX - sq_sum) sq_sum = SQ_SUM_MAX;
      else sq_sum += sq;

      step_count++;

      // bin strictly inside the range, clamp an overrun to the last bin
      if (h_lo < np && np < h_hi) begin
        idx = ((np - h_lo) * scale) >>> 24;
        if (idx > HIST_BINS - 1) idx = HIST_BINS - 1;
        if (bin_hits[idx] != 32'hFFFF_FFFF) bin_hits[idx]++;
      end

      // flip the pull once the far threshold is crossed
      if (pull_r ? (np >= thresh) : (np <= -thresh)) begin
        pull_r = !pull_r;
        if (flip_count != 32'hFFFF_FFFF) flip_count++;
      end
    endfunction

    // Predict the report for one accepted transaction
    function void log_request(logic func, logic signed [23:0] noise, logic [7:0] bidx);
      walker_report_t r;
      r.bin_count = '0;
      if (func == FUNC_STEP) begin
        if (step_count < step_limit) advance_walker(longint'(noise));
      end else begin
        r.bin_count = bin_hits[bidx];
      end
      r.position     = pos[23:0];
      r.pull_right   = pull_r;
      r.switches     = flip_count;
      r.steps_taken  = step_count;
      r.square_total = sq_sum[62:0];
      r.done_res     = (step_count >= step_limit);
      predicted_reports.push_back(r);
    endfunction

    function int waiting();
      return predicted_reports.size();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Check one returned report against the oldest prediction
    function void check_report(walker_report_t got);
      walker_report_t want;
      if (predicted_reports.size() == 0) begin
        $display("%0t: report with nothing pending, actual %0h", $time, got);
        errors++;
        return;
      end
      want = predicted_reports.pop_front();
      compare_field("position", 64'(want.position), 64'(got.position));
      compare_field("pull_right", 64'(want.pull_right), 64'(got.pull_right));
      compare_field("switches", 64'(want.switches), 64'(got.switches));
      compare_field("steps_taken", 64'(want.steps_taken), 64'(got.steps_taken));
      compare_field("square_total", 64'(want.square_total), 64'(got.square_total));
      compare_field("bin_count", 64'(want.bin_count), 64'(got.bin_count));
      compare_field("done_res", 64'(want.done_res), 64'(got.done_res));
    endfunction

  endclass

endpackage

[verif/tb_switching_well_langevin_step.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_switching_well_langevin_step: testbench for the Langevin stepper
// Directed steps and reads at register extremes, end-of-run and empty-range
// cases, then random traffic under four idling patterns, with a long receiver
// hold-off and a full drain pause. Every report is checked against a shadow.
// ----------------------------------------------------------------------------
module tb_switching_well_langevin_step;

  import swls_pkg::*;
  import walker_check_pkg::*;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_CYCLES    = 150;
  localparam int          DRAIN_CYCLES   = 16;
  localparam logic [2:0]  REG_NONE       = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_func;
  logic signed [23:0]   in_noise;
  logic [7:0]           in_bin_index;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [23:0]   out_position;
  logic                 out_pull_right;
  logic [31:0]          out_switches;
  logic [31:0]          out_steps_taken;
  logic [62:0]          out_square_total;
  logic [31:0]          out_bin_count;
  logic                 out_done_res;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [CFG_AW-1:0]    cfg_paddr;
  logic [CFG_DW-1:0]    cfg_pwdata;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  walker_tracker  tracker;
  walker_report_t seen;
  int             idle_pct;
  int             stall_pct;
  bit             hold_req;
  int             quiet_cycles;

  switching_well_langevin_step dut (.*);

  assign seen = {out_position, out_pull_right, out_switches, out_steps_taken,
                 out_square_total, out_bin_count, out_done_res};

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check every report the block hands over
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && !out_stall) tracker.check_report(seen);
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_switching_well_langevin_step: errors");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one transaction, hold it until accepted, then drop valid
  task automatic offer(input logic func, input logic signed [23:0] noise,
                       input logic [7:0] bidx);
    while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    in_valid     = 1'b1;
    in_func      = func;
    in_noise     = noise;
    in_bin_index = bidx;
    do @(posedge clk); while (in_stall);
    tracker.log_request(func, noise, bidx);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait for every pending report, then let the block go quiet
  task automatic settle();
    while (tracker.waiting() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then access cycle
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic [23:0] gain, input logic [22:0] off,
                            input logic [22:0] thr, input logic [23:0] lo,
                            input logic [23:0] hi, input logic [15:0] scale,
                            input logic [31:0] limit);
    settle();
    apb_write(REG_DRIFT_GAIN, 32'(gain));
    apb_write(REG_WELL_OFFSET, 32'(off));
    apb_write(REG_FLIP_THRESHOLD, 32'(thr));
    apb_write(REG_HIST_LOW, 32'(lo));
    apb_write(REG_HIST_HIGH, 32'(hi));
    apb_write(REG_BIN_SCALE, 32'(scale));
    apb_write(REG_MAX_STEPS, limit);
  endtask

  // Symmetric histogram range with a roughly matching bin scale
  task automatic shuffle_config(input logic [31:0] limit);
    int         k;
    logic [22:0] off;
    k   = $urandom_range(17, 20);
    off = 23'($urandom_range(1 << 15, 1 << 19));
    set_config(24'($urandom_range(0, 1 << 20)), off, 23'($urandom_range(0, off)),
               24'(-(1 << (k - 1))), 24'(1 << (k - 1)),
               16'((1 << (32 - k)) + $urandom_range(0, 3) * 64), limit);
  endtask

  // Mostly small noise, some full-range values and rail hits
  function automatic logic signed [23:0] pick_noise();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       pick_noise = r[23:0];
      1:       pick_noise = r[0] ? 24'sh7FFFFF : 24'sh800000;
      default: pick_noise = {{6{r[17]}}, r[17:0]};
    endcase
  endfunction

  task automatic random_phase(input int count, input int in_pct, input int out_pct,
                              input bit squeeze);
    idle_pct  = in_pct;
    stall_pct = out_pct;
    for (int k = 0; k < count; k++) begin
      // fill the block against a held receiver, later drain it completely
      if (squeeze && k == 20) hold_req = 1'b1;
      if (squeeze && k == 70) while (tracker.waiting() != 0) @(negedge clk);
      offer(($urandom_range(0, 3) == 0) ? FUNC_READ : FUNC_STEP, pick_noise(),
            8'($urandom));
    end
  endtask

  initial begin
    tracker      = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_func      = FUNC_STEP;
    in_noise     = '0;
    in_bin_index = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: rails, flips both ways, reads of untouched bins
    offer(FUNC_STEP, 24'sh000000, 8'h00);
    offer(FUNC_STEP, 24'sh7FFFFF, 8'hFF);
    offer(FUNC_STEP, 24'sh800000, 8'h00);
    offer(FUNC_STEP, 24'sh800000, 8'h00);
    offer(FUNC_STEP, 24'sh7FFFFF, 8'h00);
    offer(FUNC_STEP, 24'sh000000, 8'h00);
    offer(FUNC_READ, 24'sh000000, 8'h00);
    offer(FUNC_READ, 24'sh7FFFFF, 8'hFF);
    offer(FUNC_READ, 24'sh800000, 8'h32);

    // Register maxima, zero threshold, oversized bin scale; stray index
    set_config(24'hFFFFFF, 23'h7FFFFF, 23'h000000, 24'h800000, 24'h7FFFFF,
               16'hFFFF, 32'hFFFF_FFFF);
    apb_write(REG_NONE, $urandom);
    offer(FUNC_STEP, 24'sh000000, 8'h00);
    offer(FUNC_STEP, 24'sh7FFFFF, 8'h00);
    offer(FUNC_STEP, 24'sh800000, 8'h00);
    offer(FUNC_READ, 24'sh000000, 8'hFF);
    offer(FUNC_READ, 24'sh000000, 8'h00);

    // Register zeros with a reversed histogram range
    set_config(24'h000000, 23'h000000, 23'h7FFFFF, 24'h000100, 24'hFFFF00,
               16'h0000, 32'hFFFF_FFFF);
    offer(FUNC_STEP, 24'sh000010, 8'h00);
    offer(FUNC_STEP, 24'shFFFFF0, 8'h00);
    offer(FUNC_READ, 24'sh000000, 8'hFF);

    // End of run: two more steps allowed, then ignored; then a zero limit
    set_config(24'h010000, 23'h050000, 23'h004000, 24'hFE0000, 24'h020000,
               16'd12800, tracker.step_count + 32'd2);
    offer(FUNC_STEP, 24'sh001000, 8'h00);
    offer(FUNC_STEP, 24'sh001000, 8'h00);
    offer(FUNC_STEP, 24'sh001000, 8'h00);
    offer(FUNC_READ, 24'sh000000, 8'h80);
    settle();
    apb_write(REG_MAX_STEPS, 32'd0);
    offer(FUNC_STEP, 24'sh7FFFFF, 8'h00);
    offer(FUNC_READ, 24'sh000000, 8'h7F);

    // Random traffic under each idling pattern
    shuffle_config(32'hFFFF_FFFF);
    random_phase(132, 0, 0, 1'b1);
    shuffle_config(tracker.step_count + 32'd90);
    random_phase(132, 60, 0, 1'b0);
    shuffle_config(32'hFFFF_FFF0);
    random_phase(132, 0, 60, 1'b0);
    shuffle_config(32'hFFFF_FFFF);
    random_phase(132, 22, 22, 1'b0);

    settle();
    if (tracker.errors == 0)
      $display("tb_switching_well_langevin_step: clean");
    else
      $display("tb_switching_well_langevin_step: errors");
    $finish;
  end

endmodule

[switching_well_langevin_step.f]
rtl/swls_pkg.sv
rtl/switching_well_langevin_step.sv
verif/walker_check_pkg.sv
verif/tb_switching_well_langevin_step.sv
